@@ rtl/two_value_multimap_table_defines.svh @@
// Assertion macros for the two-value multimap table checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef TWO_VALUE_MULTIMAP_TABLE_DEFINES_SVH
`define TWO_VALUE_MULTIMAP_TABLE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TVMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TVMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tvmt_pkg.sv @@
// Package for the two-value multimap table: widths, codes and shared structs.
// No dependencies; used by the cell, the top level and the checker.
package tvmt_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int PC_W        = 5;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_FIELD_W = 75;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // Request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_KEY_TWICE = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL     = 1'b1;

  localparam int          CAP_RESET   = 16;
  localparam logic [1:0]  MAX_PER_KEY = 2'd2;

  // Request held while the chain evaluates
  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } tvmt_req_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic [1:0]              hits;
    logic signed [VAL_W-1:0] first;
    logic signed [VAL_W-1:0] second;
    logic                    pair_hit;
    logic signed [KEY_W-1:0] last_key;
    logic signed [VAL_W-1:0] last_val;
  } tvmt_link_t;

  // Write controls broadcast to all cells
  typedef struct packed {
    logic                    add_en;
    logic                    rem_en;
    logic signed [KEY_W-1:0] last_key;
    logic signed [VAL_W-1:0] last_val;
  } tvmt_ctl_t;

endpackage

@@ rtl/tvmt_cell.sv @@
// One slot of the multimap table: holds a key/value pair and matches it.
// Depends on tvmt_pkg; chained by the top level in slot order.
module tvmt_cell #(
  parameter int DEPTH = tvmt_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                           clk_i,
  input  tvmt_pkg::tvmt_req_t            req_i,
  input  logic [$clog2(DEPTH+1)-1:0]     count_i,
  input  tvmt_pkg::tvmt_ctl_t            ctl_i,
  input  tvmt_pkg::tvmt_link_t           link_i,
  output tvmt_pkg::tvmt_link_t           link_o
);
  import tvmt_pkg::*;

  localparam int             CW     = $clog2(DEPTH + 1);
  localparam logic [CW-1:0]  IDX_C  = CW'(IDX);
  localparam logic [CW-1:0]  LAST_C = CW'(IDX + 1);

  logic signed [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    in_use;
  logic                    key_hit;
  logic                    pair_hit;
  logic                    own_hit;

  // Match against the broadcast request
  assign in_use   = IDX_C < count_i;
  assign key_hit  = in_use && (key_q == req_i.key);
  assign pair_hit = key_hit && (val_q == req_i.value);
  assign own_hit  = pair_hit && !link_i.pair_hit;

  // Pass match count, found values, first pair hit and last slot along
  always_comb begin
    link_o = link_i;
    if (key_hit && (link_i.hits != MAX_PER_KEY)) begin
      link_o.hits = link_i.hits + 2'd1;
    end
    if (key_hit && (link_i.hits == 2'd0)) begin
      link_o.first = val_q;
    end
    if (key_hit && (link_i.hits == 2'd1)) begin
      link_o.second = val_q;
    end
    link_o.pair_hit = link_i.pair_hit | pair_hit;
    if (LAST_C == count_i) begin
      link_o.last_key = key_q;
      link_o.last_val = val_q;
    end
  end

  // Load on append at the next free slot, or fill the hole on remove
  always_ff @(posedge clk_i) begin
    if (ctl_i.add_en && (IDX_C == count_i)) begin
      key_q <= req_i.key;
      val_q <= req_i.value;
    end else if (ctl_i.rem_en && own_hit) begin
      key_q <= ctl_i.last_key;
      val_q <= ctl_i.last_val;
    end
  end

endmodule

@@ rtl/two_value_multimap_table.sv @@
// Two-value multimap table: a fixed-capacity key/value store, two values per key.
//
// Channels: requests come in on the s_axis group (tuser carries the kind: add,
// search or remove; tdata carries key and value). Each request yields exactly one
// result word on m_axis with status, search results, pair count, empty/full flags.
// Configuration (capacity in use, null value) is written through cfg_we_i /
// cfg_index_i / cfg_data_i, by the user only while idle; the block does not check.
//
// Timing: an accepted word is registered; while the block is busy the row
// of slot cells matches every stored pair against it at once, the match count
// and found values ripple down the cell chain, and once the output register is
// free the table is updated and the result word is registered. The block takes
// no new request until then, as it has one request register and a single
// compare-and-update pass through the cell chain.
//
// Reset empties the table (count zero), sets capacity in use to 16 and the
// null value to 0. When the receiver stalls, the result word holds; the block
// still accepts one more request and then waits with the update pending until
// the output register frees up.
module two_value_multimap_table #(
  parameter int DEPTH = tvmt_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tvmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // key[31:0], value[63:32]
  input  logic [tvmt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // kind[1:0]
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], found_count[3:2], first_value[35:4], second_value[67:36],
  // pair_count[72:68], is_empty[73], is_full[74], zero pad[79:75]
  output logic [tvmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [tvmt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tvmt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tvmt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  state_e                  state_q;
  tvmt_req_t               req_q;
  logic [CW-1:0]           count_q, count_d;
  logic [CAP_W-1:0]        cap_q;
  logic signed [VAL_W-1:0] null_q;
  logic                    m_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;

  tvmt_link_t              links [DEPTH+1];
  tvmt_ctl_t               ctl;
  logic [EW-1:0]           cap_eff;
  logic [EW-1:0]           count_ext;
  logic                    accept;
  logic                    commit;
  logic                    add_ok;
  logic                    rem_ok;
  logic [1:0]              status;
  logic [1:0]              found;
  logic signed [VAL_W-1:0] first_v;
  logic signed [VAL_W-1:0] second_v;
  logic                    is_full;
  logic                    is_empty;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_BUSY) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Clamp the capacity register into one to DEPTH
  always_comb begin
    cap_eff = EW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(cap_q) > EW'(DEPTH)) begin
      cap_eff = EW'(DEPTH);
    end
  end
  assign count_ext = EW'(count_q);

  // Head of the cell chain
  always_comb begin
    links[0]          = '0;
    links[0].first    = null_q;
    links[0].second   = null_q;
  end

  // Row of slot cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tvmt_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .req_i   (req_q),
      .count_i (count_q),
      .ctl_i   (ctl),
      .link_i  (links[g]),
      .link_o  (links[g+1])
    );
  end

  assign add_ok = (count_ext < cap_eff) && (links[DEPTH].hits != MAX_PER_KEY);
  assign rem_ok = links[DEPTH].pair_hit;

  // Decide result and table update from the chain output
  always_comb begin
    status   = STATUS_OK;
    found    = 2'd0;
    first_v  = null_q;
    second_v = null_q;
    count_d  = count_q;
    ctl          = '0;
    ctl.last_key = links[DEPTH].last_key;
    ctl.last_val = links[DEPTH].last_val;
    unique case (req_q.kind)
      KIND_ADD: begin
        if (count_ext >= cap_eff) begin
          status = STATUS_FULL;
        end else if (links[DEPTH].hits == MAX_PER_KEY) begin
          status = STATUS_KEY_TWICE;
        end else begin
          count_d = count_q + CW'(1);
        end
        ctl.add_en = commit && add_ok;
      end
      KIND_SEARCH: begin
        found    = links[DEPTH].hits;
        first_v  = links[DEPTH].first;
        second_v = links[DEPTH].second;
      end
      KIND_REMOVE: begin
        if (rem_ok) begin
          count_d = count_q - CW'(1);
        end else begin
          status = STATUS_NOT_FOUND;
        end
        ctl.rem_en = commit && rem_ok;
      end
      KIND_NOP: begin
      end
    endcase
  end

  assign is_empty = (count_d == '0);
  assign is_full  = (EW'(count_d) >= cap_eff);

  // Sequencer, count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (commit) begin
            state_q <= ST_IDLE;
            count_q <= count_d;
          end
        end
      endcase
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.kind  <= s_axis_tuser[1:0];
      req_q.key   <= s_axis_tdata[KEY_W-1:0];
      req_q.value <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (commit) begin
      out_data_q <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), is_full, is_empty,
                     PC_W'(count_d), second_v, first_v, found, status};
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(CAP_RESET);
      null_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_NULL:     null_q <= cfg_data_i[VAL_W-1:0];
      endcase
    end
  end

endmodule

@@ rtl/tvmt_checker.sv @@
// Port-level checks for the two-value multimap table, bound to the top level.
// Depends on tvmt_pkg and two_value_multimap_table_defines.svh.
`include "two_value_multimap_table_defines.svh"

module tvmt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tvmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import tvmt_pkg::*;

  logic [1:0]      status;
  logic [1:0]      found;
  logic [PC_W-1:0] pair_count;
  logic            is_empty;

  // Unpack the result word
  assign status     = m_axis_tdata[1:0];
  assign found      = m_axis_tdata[3:2];
  assign pair_count = m_axis_tdata[72:68];
  assign is_empty   = m_axis_tdata[73];

  // A request occupies the block until its compare-and-update pass is done
  `TVMT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "request accepted back to back")

  // Empty flag agrees with the pair count
  `TVMT_ASSERT(a_empty_flag, !m_axis_tvalid || (is_empty == (pair_count == '0)),
    "empty flag disagrees with pair count")

  // Search hits always come with an ok status and never exceed two
  `TVMT_ASSERT(a_found_ok, !m_axis_tvalid || (found == 2'd0) ||
    ((status == STATUS_OK) && (found != 2'd3)), "bad search result word")

  // A stalled result word holds
  `TVMT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

endmodule

bind two_value_multimap_table tvmt_checker u_tvmt_checker (.*);
